// File: rtl/core/ucbs_pkg.sv
package ucbs_pkg;

  localparam int MAX_SEG    = 32;
  localparam int COEFF_W    = 16;
  localparam int TBL_DEPTH  = MAX_SEG + 3;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int NUM_BANKS  = 4;
  localparam int BSEL_W     = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH = (TBL_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int FRAC_W = 16;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int OUT_W  = 16;
  localparam int K_W    = $clog2(MAX_SEG + 1);
  localparam int S_W    = FRAC_W + K_W;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] SEG_RESET = CNT_W'(20);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EVAL  = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [TBL_AW-1:0]         idx;
    logic signed [COEFF_W-1:0] value;
    logic [FRAC_W-1:0]         frac;
  } q_item_t;

endpackage

// File: rtl/core/ucbs_front.sv
module ucbs_front import ucbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_segment_count,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [IDX_W-1:0]        in_coeff_index,
  input  logic signed [VAL_W-1:0] in_coeff_value,
  input  logic [FRAC_W-1:0]       in_position,
  input  logic                    q_full,
  output logic                    push,
  output q_item_t                 push_item
);

  logic [CNT_W-1:0] seg_cnt_r;
  logic [K_W-1:0]   k_eff;
  logic [S_W-1:0]   scaled;
  logic             accept;
  logic             idx_ok;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seg_cnt_r <= cfg_segment_count;
    end
  end

  always_comb begin
    priority if (seg_cnt_r == '0) begin
      k_eff = K_W'(1);
    end else if (seg_cnt_r > CNT_W'(MAX_SEG)) begin
      k_eff = K_W'(MAX_SEG);
    end else begin
      k_eff = K_W'(seg_cnt_r);
    end
  end

  assign scaled = S_W'(in_position) * S_W'(k_eff);
  assign idx_ok = in_coeff_index < IDX_W'(TBL_DEPTH);

  always_comb begin
    push_item = '0;
    if (in_mode == MODE_WRITE) begin
      push_item.op    = OP_WRITE;
      push_item.idx   = TBL_AW'(in_coeff_index);
      push_item.value = COEFF_W'(in_coeff_value);
    end else begin
      push_item.op    = (in_position == '0) ? OP_ZERO : OP_EVAL;
      push_item.idx   = TBL_AW'(scaled >> FRAC_W);
      push_item.frac  = scaled[FRAC_W-1:0];
    end
  end

  // out-of-range writes are dropped here
  assign push = accept && ((in_mode == MODE_EVAL) || idx_ok);

endmodule

// File: rtl/core/ucbs_queue.sv
module ucbs_queue import ucbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head_item
);

  q_item_t        slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = cnt_r == (QAW+1)'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_item  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/ucbs_back.sv
module ucbs_back import ucbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  q_item_t                 head_item,
  output logic                    pop,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_spline_value
);

  localparam int A_W    = COEFF_W + 4;
  localparam int X2_W   = 2 * FRAC_W;
  localparam int X3_W   = 3 * FRAC_W;
  localparam int LO_W   = X3_W / 2;
  localparam int HI_W   = X3_W - LO_W;
  localparam int P1_W   = A_W + FRAC_W + 1;
  localparam int P2_W   = A_W + X2_W + 1;
  localparam int P3H_W  = A_W + HI_W + 1;
  localparam int P3L_W  = A_W + LO_W + 1;
  localparam int SUM_W  = COEFF_W + X3_W + 8;
  localparam int DIV_SH0 = X3_W + 1;
  localparam int QW     = SUM_W - DIV_SH0;
  localparam int NW     = COEFF_W + 3;
  localparam int DIV_B  = 2 ** (COEFF_W + 1);
  localparam int DIV_OFS = 3 * DIV_B;
  localparam int DIV_SH = COEFF_W + 5;
  localparam int RECIP  = (2 ** DIV_SH + 2) / 3;
  localparam int PR_W   = NW + DIV_SH;
  localparam int QS_W   = NW + 1;
  localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(3) <<< X3_W;

  logic is_write, is_eval, is_zero;

  always_comb begin
    is_write = 1'b0;
    is_eval  = 1'b0;
    is_zero  = 1'b0;
    unique case (head_item.op)
      OP_WRITE: is_write = 1'b1;
      OP_EVAL:  is_eval  = 1'b1;
      OP_ZERO:  is_zero  = 1'b1;
      default: ;
    endcase
  end

  assign pop = head_valid;

  // coefficient table, banked by index mod 4 so a window of four reads once per bank
  logic signed [COEFF_W-1:0] rd_data_r [NUM_BANKS];
  logic [BANK_AW-1:0]        wr_addr;

  assign wr_addr = BANK_AW'(head_item.idx >> BSEL_W);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic signed [COEFF_W-1:0] bank_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0]     bank_vld_r;
    logic [BSEL_W-1:0]         rd_off;
    logic [TBL_AW-1:0]         rd_ent;
    logic [BANK_AW-1:0]        rd_addr;
    logic                      wr_en;

    assign wr_en   = head_valid && is_write &&
                     (head_item.idx[BSEL_W-1:0] == BSEL_W'(b));
    assign rd_off  = BSEL_W'(b) - head_item.idx[BSEL_W-1:0];
    assign rd_ent  = head_item.idx + TBL_AW'(rd_off);
    assign rd_addr = BANK_AW'(rd_ent >> BSEL_W);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bank_vld_r <= '0;
      end else if (wr_en) begin
        bank_vld_r[wr_addr] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        bank_mem[wr_addr] <= head_item.value;
      end
      rd_data_r[b] <= bank_vld_r[rd_addr] ? bank_mem[rd_addr] : '0;
    end
  end

  // stage 1: table read, x^2
  logic                s1_vld_r, s1_zero_r;
  logic [BSEL_W-1:0]   s1_rot_r;
  logic [FRAC_W-1:0]   s1_x_r;
  logic [X2_W-1:0]     s1_x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= head_valid && (is_eval || is_zero);
    end
  end

  always_ff @(posedge clk) begin
    s1_zero_r <= is_zero;
    s1_rot_r  <= head_item.idx[BSEL_W-1:0];
    s1_x_r    <= head_item.frac;
    s1_x2_r   <= X2_W'(head_item.frac) * X2_W'(head_item.frac);
  end

  // stage 2: power-basis coefficients, x^3
  logic signed [A_W-1:0] c_ext [NUM_BANKS];
  logic signed [A_W-1:0] d20, s02, d12;
  logic signed [A_W-1:0] a_nxt [NUM_BANKS];

  always_comb begin
    for (int j = 0; j < NUM_BANKS; j++) begin
      c_ext[j] = A_W'(rd_data_r[BSEL_W'(s1_rot_r + BSEL_W'(j))]);
    end
    d20      = c_ext[2] - c_ext[0];
    s02      = c_ext[0] + c_ext[2];
    d12      = c_ext[1] - c_ext[2];
    a_nxt[0] = s02 + (c_ext[1] <<< 2);
    a_nxt[1] = (d20 <<< 1) + d20;
    a_nxt[2] = (s02 <<< 1) + s02 - (c_ext[1] <<< 2) - (c_ext[1] <<< 1);
    a_nxt[3] = c_ext[3] - c_ext[0] + (d12 <<< 1) + d12;
  end

  logic                  s2_vld_r, s2_zero_r;
  logic signed [A_W-1:0] s2_a_r [NUM_BANKS];
  logic [FRAC_W-1:0]     s2_x_r;
  logic [X2_W-1:0]       s2_x2_r;
  logic [X3_W-1:0]       s2_x3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_zero_r <= s1_zero_r;
    s2_a_r    <= a_nxt;
    s2_x_r    <= s1_x_r;
    s2_x2_r   <= s1_x2_r;
    s2_x3_r   <= X3_W'(s1_x2_r) * X3_W'(s1_x_r);
  end

  // stage 3: partial products
  logic                    s3_vld_r, s3_zero_r;
  logic signed [A_W-1:0]   s3_a0_r;
  logic signed [P1_W-1:0]  s3_p1_r;
  logic signed [P2_W-1:0]  s3_p2_r;
  logic signed [P3H_W-1:0] s3_p3h_r;
  logic signed [P3L_W-1:0] s3_p3l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_zero_r <= s2_zero_r;
    s3_a0_r   <= s2_a_r[0];
    s3_p1_r   <= P1_W'(s2_a_r[1]) * P1_W'($signed({1'b0, s2_x_r}));
    s3_p2_r   <= P2_W'(s2_a_r[2]) * P2_W'($signed({1'b0, s2_x2_r}));
    s3_p3h_r  <= P3H_W'(s2_a_r[3]) * P3H_W'($signed({1'b0, s2_x3_r[X3_W-1:LO_W]}));
    s3_p3l_r  <= P3L_W'(s2_a_r[3]) * P3L_W'($signed({1'b0, s2_x3_r[LO_W-1:0]}));
  end

  // stage 4: aligned partial sums
  logic                    s4_vld_r, s4_zero_r;
  logic signed [SUM_W-1:0] s4_a_r, s4_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_zero_r <= s3_zero_r;
    s4_a_r    <= SUM_W'(s3_p3l_r) + (SUM_W'(s3_p3h_r) <<< LO_W) + ROUND_BIAS;
    s4_b_r    <= (SUM_W'(s3_a0_r) <<< X3_W) + (SUM_W'(s3_p1_r) <<< X2_W) +
                 (SUM_W'(s3_p2_r) <<< FRAC_W);
  end

  // stage 5: floor by 2^49, offset positive for the divide by 3
  logic signed [SUM_W-1:0] total;
  logic signed [QW-1:0]    quo;
  logic                    s5_vld_r, s5_zero_r;
  logic [NW-1:0]           s5_n_r;

  assign total = s4_a_r + s4_b_r;
  assign quo   = total[SUM_W-1:DIV_SH0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_zero_r <= s4_zero_r;
    s5_n_r    <= NW'(quo + QW'(DIV_OFS));
  end

  // stage 6: divide by 3 via reciprocal, saturate
  logic [PR_W-1:0]        prod;
  logic [NW-1:0]          q_u;
  logic signed [QS_W-1:0] q_s;
  logic signed [OUT_W-1:0] sat;
  logic                   out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;

  assign prod = PR_W'(s5_n_r) * PR_W'(RECIP);
  assign q_u  = NW'(prod >> DIV_SH);
  assign q_s  = $signed({1'b0, q_u}) - QS_W'(DIV_B);

  always_comb begin
    priority if (s5_zero_r) begin
      sat = '0;
    end else if (q_s > QS_W'(OUT_MAX)) begin
      sat = OUT_W'(OUT_MAX);
    end else if (q_s < QS_W'(OUT_MIN)) begin
      sat = OUT_W'(OUT_MIN);
    end else begin
      sat = OUT_W'(q_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_vld_r) begin
      out_value_r <= sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_spline_value = out_value_r;

endmodule

// File: rtl/core/uniform_cubic_bspline_evaluator.sv
// Uniform cubic B-spline evaluator, Q0.16 position in, Q1.15 value out.
// Config: cfg_segment_count is written when cfg_valid is high (cfg_ready is
//   always high); write only while the block is idle. Reset value is 20.
// Input: a beat is taken when start is high and busy is low. in_mode 0 writes
//   in_coeff_value to table entry in_coeff_index (entries past 34 are ignored);
//   in_mode 1 evaluates at in_position and gives one result.
// Output: out_valid pulses for one cycle with out_spline_value; there is no
//   back-pressure, the receiver must take every beat.
// Order: an accepted beat passes through the queue and then the pipeline.
//   A write is visible to an evaluate accepted in the next cycle.
// Throughput: one beat per clock while busy is low. The table sits in four
//   banks indexed by entry mod 4, so the four coefficients of a segment come
//   out of one read; the arithmetic is a six-stage pipeline after a two-entry
//   queue. busy stays low in normal use as the back end drains every cycle.
// Reset: rst_n is synchronous; it clears the table to zero through per-entry
//   valid bits and empties the pipeline.
module uniform_cubic_bspline_evaluator import ucbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_segment_count,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [IDX_W-1:0]        in_coeff_index,
  input  logic signed [VAL_W-1:0] in_coeff_value,
  input  logic [FRAC_W-1:0]       in_position,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_spline_value
);

  logic    q_full, push, pop, head_valid;
  q_item_t push_item, head_item;

  ucbs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_segment_count (cfg_segment_count),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_coeff_index    (in_coeff_index),
    .in_coeff_value    (in_coeff_value),
    .in_position       (in_position),
    .q_full            (q_full),
    .push              (push),
    .push_item         (push_item)
  );

  ucbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ucbs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_spline_value (out_spline_value)
  );

`ifndef NO_ASSERTIONS
  a_eval_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_EVAL) |-> ##7 out_valid)
    else $error("evaluate beat without result after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_mode == MODE_EVAL, 7))
    else $error("result beat without matching evaluate beat");

  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_EVAL && in_position == '0)
      |-> ##7 (out_spline_value == '0))
    else $error("position zero did not give zero");

  a_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled although back end drains every cycle");
`endif

endmodule
